### rtl/core/scaled_glyph_rect_generator_assert.svh
// Assertion macros shared by the glyph rectangle generator RTL.
`ifndef SCALED_GLYPH_RECT_GENERATOR_ASSERT_SVH
`define SCALED_GLYPH_RECT_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: cons must hold whenever ante holds.
`define SGRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication: cons must hold in the cycle after ante.
`define SGRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SGRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SGRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/sgrg_pkg.sv
// Shared types, constants, font table and helper functions of the glyph rectangle generator.
package sgrg_pkg;

  localparam logic [7:0]  CODE_FIRST        = 8'd32;
  localparam logic [7:0]  CODE_LAST         = 8'd126;
  localparam int          GLYPH_COUNT       = 95;
  localparam int          GLYPH_COLS        = 5;
  localparam int          GLYPH_ROWS        = 7;
  localparam logic [2:0]  COL_LAST          = 3'd4;
  localparam logic [2:0]  ROW_LAST          = 3'd6;
  localparam logic        REG_PANEL_WIDTH   = 1'b0;
  localparam logic [15:0] PANEL_WIDTH_RESET = 16'd320;

  typedef struct packed {
    logic        start_of_string;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  scale;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [7:0]  rect_w;
    logic [10:0] rect_h;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_rect;
  } out_item_t;

  // One entry per printable code, five columns, bit n of a column is row n.
  localparam logic [6:0] FONT_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{7'h00,7'h00,7'h00,7'h00,7'h00}, '{7'h00,7'h00,7'h5F,7'h00,7'h00},
    '{7'h00,7'h07,7'h00,7'h07,7'h00}, '{7'h14,7'h7F,7'h14,7'h7F,7'h14},
    '{7'h24,7'h2A,7'h7F,7'h2A,7'h12}, '{7'h23,7'h13,7'h08,7'h64,7'h62},
    '{7'h36,7'h49,7'h55,7'h22,7'h50}, '{7'h00,7'h05,7'h03,7'h00,7'h00},
    '{7'h00,7'h1C,7'h22,7'h41,7'h00}, '{7'h00,7'h41,7'h22,7'h1C,7'h00},
    '{7'h14,7'h08,7'h3E,7'h08,7'h14}, '{7'h08,7'h08,7'h3E,7'h08,7'h08},
    '{7'h00,7'h50,7'h30,7'h00,7'h00}, '{7'h08,7'h08,7'h08,7'h08,7'h08},
    '{7'h00,7'h60,7'h60,7'h00,7'h00}, '{7'h20,7'h10,7'h08,7'h04,7'h02},
    '{7'h3E,7'h51,7'h49,7'h45,7'h3E}, '{7'h00,7'h42,7'h7F,7'h40,7'h00},
    '{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4B,7'h31},
    '{7'h18,7'h14,7'h12,7'h7F,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
    '{7'h3C,7'h4A,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
    '{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1E},
    '{7'h00,7'h36,7'h36,7'h00,7'h00}, '{7'h00,7'h56,7'h36,7'h00,7'h00},
    '{7'h08,7'h14,7'h22,7'h41,7'h00}, '{7'h14,7'h14,7'h14,7'h14,7'h14},
    '{7'h00,7'h41,7'h22,7'h14,7'h08}, '{7'h02,7'h01,7'h51,7'h09,7'h06},
    '{7'h32,7'h49,7'h79,7'h41,7'h3E}, '{7'h7E,7'h11,7'h11,7'h11,7'h7E},
    '{7'h7F,7'h49,7'h49,7'h49,7'h36}, '{7'h3E,7'h41,7'h41,7'h41,7'h22},
    '{7'h7F,7'h41,7'h41,7'h22,7'h1C}, '{7'h7F,7'h49,7'h49,7'h49,7'h41},
    '{7'h7F,7'h09,7'h09,7'h09,7'h01}, '{7'h3E,7'h41,7'h49,7'h49,7'h7A},
    '{7'h7F,7'h08,7'h08,7'h08,7'h7F}, '{7'h00,7'h41,7'h7F,7'h41,7'h00},
    '{7'h20,7'h40,7'h41,7'h3F,7'h01}, '{7'h7F,7'h08,7'h14,7'h22,7'h41},
    '{7'h7F,7'h40,7'h40,7'h40,7'h40}, '{7'h7F,7'h02,7'h0C,7'h02,7'h7F},
    '{7'h7F,7'h04,7'h08,7'h10,7'h7F}, '{7'h3E,7'h41,7'h41,7'h41,7'h3E},
    '{7'h7F,7'h09,7'h09,7'h09,7'h06}, '{7'h3E,7'h41,7'h51,7'h21,7'h5E},
    '{7'h7F,7'h09,7'h19,7'h29,7'h46}, '{7'h46,7'h49,7'h49,7'h49,7'h31},
    '{7'h01,7'h01,7'h7F,7'h01,7'h01}, '{7'h3F,7'h40,7'h40,7'h40,7'h3F},
    '{7'h1F,7'h20,7'h40,7'h20,7'h1F}, '{7'h3F,7'h40,7'h38,7'h40,7'h3F},
    '{7'h63,7'h14,7'h08,7'h14,7'h63}, '{7'h07,7'h08,7'h70,7'h08,7'h07},
    '{7'h61,7'h51,7'h49,7'h45,7'h43}, '{7'h00,7'h7F,7'h41,7'h41,7'h00},
    '{7'h02,7'h04,7'h08,7'h10,7'h20}, '{7'h00,7'h41,7'h41,7'h7F,7'h00},
    '{7'h04,7'h02,7'h01,7'h02,7'h04}, '{7'h40,7'h40,7'h40,7'h40,7'h40},
    '{7'h00,7'h01,7'h02,7'h04,7'h00}, '{7'h20,7'h54,7'h54,7'h54,7'h78},
    '{7'h7F,7'h48,7'h44,7'h44,7'h38}, '{7'h38,7'h44,7'h44,7'h44,7'h20},
    '{7'h38,7'h44,7'h44,7'h48,7'h7F}, '{7'h38,7'h54,7'h54,7'h54,7'h18},
    '{7'h08,7'h7E,7'h09,7'h01,7'h02}, '{7'h0C,7'h52,7'h52,7'h52,7'h3E},
    '{7'h7F,7'h08,7'h04,7'h04,7'h78}, '{7'h00,7'h44,7'h7D,7'h40,7'h00},
    '{7'h20,7'h40,7'h44,7'h3D,7'h00}, '{7'h7F,7'h10,7'h28,7'h44,7'h00},
    '{7'h00,7'h41,7'h7F,7'h40,7'h00}, '{7'h7C,7'h04,7'h18,7'h04,7'h78},
    '{7'h7C,7'h08,7'h04,7'h04,7'h78}, '{7'h38,7'h44,7'h44,7'h44,7'h38},
    '{7'h7C,7'h14,7'h14,7'h14,7'h08}, '{7'h08,7'h14,7'h14,7'h18,7'h7C},
    '{7'h7C,7'h08,7'h04,7'h04,7'h08}, '{7'h48,7'h54,7'h54,7'h54,7'h20},
    '{7'h04,7'h3F,7'h44,7'h40,7'h20}, '{7'h3C,7'h40,7'h40,7'h20,7'h7C},
    '{7'h1C,7'h20,7'h40,7'h20,7'h1C}, '{7'h3C,7'h40,7'h30,7'h40,7'h3C},
    '{7'h44,7'h28,7'h10,7'h28,7'h44}, '{7'h0C,7'h50,7'h50,7'h50,7'h3C},
    '{7'h44,7'h64,7'h54,7'h4C,7'h44}, '{7'h00,7'h08,7'h36,7'h41,7'h00},
    '{7'h00,7'h00,7'h7F,7'h00,7'h00}, '{7'h00,7'h41,7'h36,7'h08,7'h00},
    '{7'h10,7'h08,7'h08,7'h10,7'h08}
  };

  // Map a character byte to its font entry; non-printable codes use the space.
  function automatic logic [6:0] glyph_index(input logic [7:0] code);
    logic [7:0] offset;
    offset = code - CODE_FIRST;
    if ((code < CODE_FIRST) || (code > CODE_LAST)) begin
      return 7'd0;
    end
    return offset[6:0];
  endfunction

  // Expand RGB565 into top-aligned 8-bit channels {red, green, blue}.
  function automatic logic [23:0] rgb565_expand(input logic [15:0] color);
    return {color[15:11], 3'b000, color[10:5], 2'b00, color[4:0], 3'b000};
  endfunction

endpackage

### rtl/core/sgrg_seq.sv
// Glyph sequencer: clip check, then cell walk and cursor advance around one shared adder.
`include "scaled_glyph_rect_generator_assert.svh"

module sgrg_seq
  import sgrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  in_item_t    item,
  output logic        busy,
  input  logic [15:0] panel_width,
  output logic        rect_valid,
  output out_item_t   rect,
  input  logic        rect_take
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_CELL   = 4'b0100,
    S_SPACER = 4'b1000
  } seq_state_t;

  seq_state_t  state_r, state_nxt;
  logic [15:0] cursor_r, cursor_nxt;
  logic        stopped_r, stopped_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [2:0]  row_r, row_nxt;

  // Item payload, loaded on accept.
  logic [15:0] origin_y_r;
  logic [6:0]  glyph_r;
  logic [15:0] fg_r;
  logic [15:0] bg_r;
  logic [7:0]  scale_r;

  logic        accept;
  logic [10:0] step;
  logic [10:0] spacer_h;
  logic [16:0] reach;
  logic [15:0] add_a;
  logic [15:0] add_sum;
  logic        dot_on;
  logic [23:0] rgb;

  assign accept   = item_valid && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);

  // 6*scale by shift and add, 7*scale by shift and subtract.
  assign step     = {1'b0, scale_r, 2'b00} + {2'b00, scale_r, 1'b0};
  assign spacer_h = {scale_r, 3'b000} - {3'b000, scale_r};
  assign reach    = {1'b0, cursor_r} + {6'd0, step};

  // Shared adder: step down a column, otherwise step across.
  assign add_a    = ((state_r == S_CELL) && (row_r != ROW_LAST)) ? y_r : x_r;
  assign add_sum  = add_a + {8'd0, scale_r};

  assign dot_on   = FONT_ROM[glyph_r][col_r][row_r];
  assign rgb      = rgb565_expand(((state_r == S_CELL) && dot_on) ? fg_r : bg_r);

  always_comb begin
    rect_valid     = (state_r == S_CELL) || (state_r == S_SPACER);
    rect.rect_x    = x_r;
    rect.rect_y    = y_r;
    rect.rect_w    = scale_r;
    rect.rect_h    = (state_r == S_SPACER) ? spacer_h : {3'b000, scale_r};
    rect.red       = rgb[23:16];
    rect.green     = rgb[15:8];
    rect.blue      = rgb[7:0];
    rect.last_rect = (state_r == S_SPACER);
  end

  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    stopped_nxt = stopped_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (item.start_of_string) begin
            cursor_nxt  = item.origin_x;
            stopped_nxt = 1'b0;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stopped_r) begin
          state_nxt = S_IDLE;
        end else if (reach > {1'b0, panel_width}) begin
          stopped_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end else if (scale_r == 8'd0) begin
          state_nxt = S_IDLE;
        end else begin
          x_nxt     = cursor_r;
          y_nxt     = origin_y_r;
          col_nxt   = 3'd0;
          row_nxt   = 3'd0;
          state_nxt = S_CELL;
        end
      end
      S_CELL: begin
        if (rect_take) begin
          if (row_r != ROW_LAST) begin
            y_nxt   = add_sum;
            row_nxt = row_r + 3'd1;
          end else begin
            x_nxt   = add_sum;
            y_nxt   = origin_y_r;
            row_nxt = 3'd0;
            if (col_r != COL_LAST) begin
              col_nxt = col_r + 3'd1;
            end else begin
              row_nxt   = ROW_LAST;
              state_nxt = S_SPACER;
            end
          end
        end
      end
      S_SPACER: begin
        if (rect_take) begin
          cursor_nxt = add_sum;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cursor_r  <= 16'd0;
      stopped_r <= 1'b0;
      col_r     <= 3'd0;
      row_r     <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      cursor_r  <= cursor_nxt;
      stopped_r <= stopped_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    if (accept) begin
      origin_y_r <= item.origin_y;
      glyph_r    <= glyph_index(item.char_code);
      fg_r       <= item.fg_color;
      bg_r       <= item.bg_color;
      scale_r    <= item.scale;
    end
  end

  `SGRG_ASSERT_SAME(a_rect_scale_nonzero, clk, rst_n, rect_valid, scale_r != 8'd0, "rectangle with zero scale")
  `SGRG_ASSERT_SAME(a_cell_in_range, clk, rst_n, state_r == S_CELL, (col_r <= COL_LAST) && (row_r <= ROW_LAST), "cell index out of range")
  `SGRG_ASSERT_NEXT(a_spacer_advances, clk, rst_n, (state_r == S_SPACER) && rect_take, (state_r == S_IDLE) && (cursor_r == $past(add_sum)), "cursor not advanced after spacer")

endmodule

### rtl/core/scaled_glyph_rect_generator.sv
// Top level of the scaled glyph rectangle generator: register port, sequencer, output register.
//
// Each input transaction carries one character; the block answers with the filled rectangles
// that paint it from a built-in 5x7 font (ASCII 32..126, anything else drawn as a space):
// 35 scale-by-scale cells, column by column and rows 0..6 within a column, then one
// background spacer column of scale by 7*scale flagged by last_rect. Colors arrive as RGB565
// and leave as top-aligned 8-bit channels. A set start_of_string loads the cursor from
// origin_x; otherwise the cursor moves on by 6*scale per drawn character. A character whose
// cell would run past panel_width stops the string: it and every following character give
// no rectangles until the next start_of_string. Scale zero draws nothing and keeps the
// cursor. in_stall is high while a character is in work. A drawn character occupies the
// block through accept, a clip-check state, then 36 rectangles at one per cycle unless
// out_stall holds the output register; a clipped, stopped or zero-scale character returns to
// idle after the clip check. The rectangle walk is paced by the sequencer, which steps one
// position per cycle while rect_take is high, through a single shared 16-bit adder. A
// finished rectangle waits in the output register, so the next character is taken while
// the last one is still pending on out_. panel_width sits at byte address 0 of the APB
// port (reset 320); write it only while the block is idle.
`include "scaled_glyph_rect_generator_assert.svh"

module scaled_glyph_rect_generator
  import sgrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Character input
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // Rectangle output
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] panel_width_r, panel_width_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;

  logic        cfg_write;
  logic        seq_busy;
  logic        rect_valid;
  out_item_t   rect;
  logic        rect_take;

  // Register port: always ready, word index in paddr[2].
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PANEL_WIDTH);
  assign prdata    = (paddr[2] == REG_PANEL_WIDTH) ? {16'd0, panel_width_r} : 32'd0;

  always_comb begin
    panel_width_nxt = panel_width_r;
    if (cfg_write) begin
      panel_width_nxt = pwdata[15:0];
    end
  end

  // Hold input off while the sequencer walks a character.
  assign in_stall = seq_busy;

  sgrg_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_valid),
    .item        (in_item),
    .busy        (seq_busy),
    .panel_width (panel_width_r),
    .rect_valid  (rect_valid),
    .rect        (rect),
    .rect_take   (rect_take)
  );

  // Output register: load when empty or when the pending transaction drains this cycle.
  assign rect_take = rect_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rect_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r <= PANEL_WIDTH_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      panel_width_r <= panel_width_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rect_take) begin
      out_item_r <= rect;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SGRG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not held off after accept")
  `SGRG_ASSERT_NEXT(a_cfg_written, clk, rst_n, cfg_write, panel_width_r == $past(pwdata[15:0]), "panel width write lost")

endmodule

### bench/tb_scaled_glyph_rect_generator.sv
// Self-checking testbench for the scaled glyph rectangle generator.
module tb_scaled_glyph_rect_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import sgrg_pkg::*;

  localparam int          CLK_HALF       = 2;
  localparam int          RESET_CYCLES   = 8;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          REPORT_LIMIT   = 10;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          CHAR_SPACE     = 32;
  localparam int          CHAR_TILDE     = 126;
  localparam int          FONT_SIZE      = 95;
  localparam int          DOT_COLS       = 5;
  localparam int          DOT_ROWS       = 7;
  localparam int          ADVANCE        = 6;
  localparam logic [15:0] WIDTH_AT_RESET = 16'd320;
  // Registers sit on 4-byte boundaries.
  localparam logic [2:0]  ADDR_PANEL_WIDTH = 3'(REG_PANEL_WIDTH) << 2;

  // 5x7 font, printable ASCII from space to tilde. Byte c (from the left) is
  // column c, bit n of a column is row n.
  localparam logic [39:0] FONT5X7 [FONT_SIZE] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  // Tracks the string cursor and panel width, and turns every accepted
  // character into the rectangles the block must paint for it.
  class glyph_tracer;
    logic [15:0] width;
    logic [15:0] cursor;
    bit          stopped;
    out_item_t   due_rects[$];
    int          faults;

    function new();
      width   = WIDTH_AT_RESET;
      cursor  = '0;
      stopped = 1'b0;
      faults  = 0;
    endfunction

    function void flag(string msg);
      if (faults < REPORT_LIMIT) begin
        $display("%s", msg);
      end
      faults++;
    endfunction

    function string show(out_item_t r);
      return $sformatf("x=%0d y=%0d w=%0d h=%0d rgb=%02h/%02h/%02h last=%0b", r.rect_x,
                       r.rect_y, r.rect_w, r.rect_h, r.red, r.green, r.blue, r.last_rect);
    endfunction

    function out_item_t make_rect(logic [15:0] x, logic [15:0] y, logic [7:0] w,
                                  logic [10:0] h, logic [15:0] color, logic last);
      out_item_t r;
      r.rect_x    = x;
      r.rect_y    = y;
      r.rect_w    = w;
      r.rect_h    = h;
      r.red       = {color[15:11], 3'b000};
      r.green     = {color[10:5], 2'b00};
      r.blue      = {color[4:0], 3'b000};
      r.last_rect = last;
      return r;
    endfunction

    function void take_char(in_item_t ch);
      logic [10:0] step;
      logic [16:0] reach;
      logic [39:0] glyph;
      logic [7:0]  dots;
      logic [15:0] color;
      int          idx;
      if (ch.start_of_string) begin
        cursor  = ch.origin_x;
        stopped = 1'b0;
      end
      if (stopped) begin
        return;
      end
      step  = 11'(ch.scale) * 11'(ADVANCE);
      reach = 17'(cursor) + 17'(step);
      if (reach > 17'(width)) begin
        stopped = 1'b1;
        return;
      end
      if (ch.scale == 8'd0) begin
        return;
      end
      idx   = (int'(ch.char_code) >= CHAR_SPACE && int'(ch.char_code) <= CHAR_TILDE) ?
              int'(ch.char_code) - CHAR_SPACE : 0;
      glyph = FONT5X7[idx];
      for (int col = 0; col < DOT_COLS; col++) begin
        dots = glyph[39 - 8 * col -: 8];
        for (int row = 0; row < DOT_ROWS; row++) begin
          color = dots[row] ? ch.fg_color : ch.bg_color;
          due_rects.push_back(make_rect(cursor + 16'(col) * 16'(ch.scale),
                                        ch.origin_y + 16'(row) * 16'(ch.scale),
                                        ch.scale, 11'(ch.scale), color, 1'b0));
        end
      end
      due_rects.push_back(make_rect(cursor + 16'(DOT_COLS) * 16'(ch.scale), ch.origin_y,
                                    ch.scale, 11'(ch.scale) * 11'(DOT_ROWS),
                                    ch.bg_color, 1'b1));
      cursor = cursor + 16'(step);
    endfunction

    function void match_rect(out_item_t got);
      out_item_t want;
      string     bad;
      if (due_rects.size() == 0) begin
        flag($sformatf("unexpected rectangle: %s", show(got)));
        return;
      end
      want = due_rects.pop_front();
      bad  = "";
      if (got.rect_x !== want.rect_x)       bad = {bad, " rect_x"};
      if (got.rect_y !== want.rect_y)       bad = {bad, " rect_y"};
      if (got.rect_w !== want.rect_w)       bad = {bad, " rect_w"};
      if (got.rect_h !== want.rect_h)       bad = {bad, " rect_h"};
      if (got.red !== want.red)             bad = {bad, " red"};
      if (got.green !== want.green)         bad = {bad, " green"};
      if (got.blue !== want.blue)           bad = {bad, " blue"};
      if (got.last_rect !== want.last_rect) bad = {bad, " last_rect"};
      if (bad != "") begin
        flag($sformatf("rectangle mismatch in%s: expected %s, got %s", bad, show(want),
                       show(got)));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  glyph_tracer tracer;
  bit          hold_off;     // raised by the stimulus, cleared by the receiver
  int          chars_sent;
  int          burst_left;
  int          font_walk;

  scaled_glyph_rect_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a run that hangs: far above the slowest legal run, every character
  // fully drawn with the receiver at its longest stalls and the hold-off.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Check every rectangle that crosses the output handshake.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracer.match_rect(out_item);
    end
  end

  // Receiver: stall in segments of changing style, and hold off for a long,
  // counted stretch whenever the stimulus asks for back pressure.
  initial begin
    int span;
    int style;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_off = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(16, 160);
        for (int k = 0; k < span && !hold_off; k++) begin
          @(negedge clk);
          case (style)
            0: begin
              out_stall <= 1'b0;
            end
            1: begin
              out_stall <= ($urandom_range(0, 99) < 35);
            end
            2: begin
              out_stall <= (k % 4 == 3);
            end
            default: begin
              out_stall <= ((k / 6) % 2 == 1);
            end
          endcase
        end
      end
    end
  end

  function automatic in_item_t make_char(logic start, logic [15:0] ox, logic [15:0] oy,
                                         logic [7:0] code, logic [15:0] fg,
                                         logic [15:0] bg, logic [7:0] scale);
    in_item_t ch;
    ch.start_of_string = start;
    ch.origin_x        = ox;
    ch.origin_y        = oy;
    ch.char_code       = code;
    ch.fg_color        = fg;
    ch.bg_color        = bg;
    ch.scale           = scale;
    return ch;
  endfunction

  // Offer one character, hold it until taken, then pace the sender: bursts of
  // back-to-back transactions separated by random gaps, unless rushing.
  task automatic offer_char(input in_item_t ch, input bit rush);
    int          gap;
    logic [127:0] junk;
    @(negedge clk);
    in_item  <= ch;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tracer.take_char(ch);
    chars_sent++;
    if (rush) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 11);
    gap        = $urandom_range(1, 10);
    repeat (gap) begin
      @(negedge clk);
      junk     = {$urandom, $urandom, $urandom, $urandom};
      in_valid <= 1'b0;
      in_item  <= junk[$bits(in_item_t)-1:0];
    end
  endtask

  // Drop valid, drain every pending rectangle, then let a no-result
  // character still in flight finish before touching the register.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracer.due_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the panel width, then read it back.
  task automatic set_panel_width(input logic [15:0] w);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PANEL_WIDTH;
    pwdata  <= {16'h0000, w};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracer.width = w;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, w}) begin
      tracer.flag($sformatf("panel_width readback: expected %0d, got %0d", w, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One string: mostly a start character then continuations with one scale,
  // mixed with strings that never start, stray restarts and odd scales.
  task automatic send_string(input bit rush);
    int         len;
    int         pick;
    logic [7:0] scale;
    in_item_t   ch;
    len   = $urandom_range(1, 8);
    scale = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 6)) : 8'($urandom);
    for (int n = 0; n < len; n++) begin
      ch.start_of_string = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
      ch.origin_x = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, tracer.width / 2))
                                                : 16'($urandom);
      ch.origin_y = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        ch.char_code = 8'(CHAR_SPACE + font_walk);
        font_walk    = (font_walk + 1) % FONT_SIZE;
      end else if (pick < 85) begin
        ch.char_code = 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
      end else begin
        ch.char_code = 8'($urandom);
      end
      ch.fg_color = 16'($urandom);
      ch.bg_color = 16'($urandom);
      pick = $urandom_range(0, 19);
      ch.scale = (pick == 0) ? 8'd0 : (pick == 1) ? 8'($urandom) : scale;
      offer_char(ch, rush);
    end
  endtask

  // Reset default width: glyph edge codes, out-of-range codes, zero scale,
  // clipping, a stopped string, an exact fit at the panel edge.
  task automatic run_directed();
    offer_char(make_char(1'b1, 16'd0, 16'd0, 8'd65, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd10, 8'd126, 16'hF800, 16'h07E0, 8'd2), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd20, 8'd32, 16'h001F, 16'hFFE0, 8'd3), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd30, 8'd0, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd40, 8'd255, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd50, 8'd31, 16'h0000, 16'hFFFF, 8'd1), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd60, 8'd127, 16'h0000, 16'hFFFF, 8'd1), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd70, 8'd66, 16'hFFFF, 16'h0000, 8'd0), 1'b0);
    offer_char(make_char(1'b1, 16'd300, 16'd0, 8'd67, 16'hFFFF, 16'h0000, 8'd4), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd0, 8'd68, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    offer_char(make_char(1'b1, 16'd314, 16'd5, 8'd69, 16'h1234, 16'hFEDC, 8'd1), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd0, 8'd70, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    offer_char(make_char(1'b1, 16'd321, 16'd0, 8'd71, 16'hFFFF, 16'h0000, 8'd0), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd0, 8'd72, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    // Widest panel: largest scale right at the edge, with the rows wrapping.
    settle();
    set_panel_width(16'hFFFF);
    offer_char(make_char(1'b1, 16'd64005, 16'hFFFF, 8'd64, 16'hAAAA, 16'h5555, 8'd255),
               1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd0, 8'd65, 16'hFFFF, 16'h0000, 8'd0), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd0, 8'd66, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    offer_char(make_char(1'b1, 16'hFFFF, 16'd0, 8'd67, 16'hFFFF, 16'h0000, 8'd0), 1'b0);
    // Zero width: only zero-scale characters at column zero get through.
    settle();
    set_panel_width(16'd0);
    offer_char(make_char(1'b1, 16'd0, 16'd0, 8'd68, 16'hFFFF, 16'h0000, 8'd0), 1'b0);
    offer_char(make_char(1'b0, 16'd0, 16'd0, 8'd69, 16'hFFFF, 16'h0000, 8'd1), 1'b0);
    offer_char(make_char(1'b1, 16'd1, 16'd0, 8'd70, 16'hFFFF, 16'h0000, 8'd0), 1'b0);
  endtask

  initial begin
    logic [15:0] phase_width [RANDOM_PHASES];
    int          phase_quota [RANDOM_PHASES];
    int          phase_start;
    tracer     = new();
    hold_off   = 1'b0;
    chars_sent = 0;
    burst_left = 0;
    font_walk  = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    phase_width = '{16'hFFFF, WIDTH_AT_RESET, 16'($urandom_range(1, 3000)), 16'd1, 16'd0,
                    16'($urandom_range(1, 65535))};
    phase_quota = '{75, 75, 75, 15, 15, 75};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Random phases, each at its own panel width. The first one starts with
    // the long receiver hold-off while characters keep coming back to back.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      set_panel_width(phase_width[p]);
      phase_start = chars_sent;
      if (p == 0) begin
        hold_off = 1'b1;
        while (hold_off) send_string(1'b1);
      end
      while (chars_sent - phase_start < phase_quota[p]) send_string(1'b0);
    end

    settle();
    if (tracer.faults == 0 && tracer.due_rects.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
